/* rtl/rrb_pkg.sv */
// Shared types, constants and codes for the redundancy reorder buffer.
`timescale 1ns / 1ps
package rrb_pkg;

    localparam int QUEUE_DEPTH   = 16;
    localparam int MAX_OUT       = 16;
    localparam int WINDOW_FACTOR = 10;

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SCAN_W = $clog2(QUEUE_DEPTH);
    localparam int OUT_W  = $clog2(MAX_OUT + 1);
    localparam int PADDR_W = 3;

    localparam logic [4:0] LIMIT_RESET = 5'd16;

    // register indexes
    localparam logic REG_QUEUE_LIMIT = 1'b0;

    // input actions
    localparam logic [1:0] A_RECEIVE = 2'd0;
    localparam logic [1:0] A_DELIVER = 2'd1;
    localparam logic [1:0] A_TIMEOUT = 2'd2;

    // result kinds
    localparam logic [1:0] K_VERDICT   = 2'd0;
    localparam logic [1:0] K_DELIVERED = 2'd1;
    localparam logic [1:0] K_NONE      = 2'd2;

    // receive verdicts
    localparam logic [3:0] V_BAD_CHECKSUM = 4'd0;
    localparam logic [3:0] V_FIRST_NOT_0  = 4'd1;
    localparam logic [3:0] V_OLD          = 4'd2;
    localparam logic [3:0] V_IN_ORDER     = 4'd3;
    localparam logic [3:0] V_STORED_AHEAD = 4'd4;
    localparam logic [3:0] V_DUPLICATE    = 4'd5;
    localparam logic [3:0] V_FULL         = 4'd6;
    localparam logic [3:0] V_BEYOND_WIN   = 4'd7;
    localparam logic [3:0] V_IN_ORDER_FULL = 4'd8;

    typedef struct packed {
        logic [1:0]  action;
        logic        checksum_ok;
        logic        tx_not_started;
        logic [31:0] seq_nr;
        logic [31:0] payload_tag;
    } item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  verdict;
        logic [31:0] out_seq;
        logic [31:0] out_payload;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] seq;
        logic [31:0] payload;
    } entry_t;

    typedef struct packed {
        logic rotate;
        logic store;
        logic clear_hit;
    } cell_ctrl_t;

    typedef struct packed {
        logic        hit_a;
        logic        hit_b;
        logic [31:0] hit_payload;
        logic        tail_valid;
        logic [31:0] tail_seq;
    } chain_stat_t;

endpackage

/* rtl/rrb_cell.sv */
// One defer queue cell: holds an entry, matches keys, joins the free and select chains.
`timescale 1ns / 1ps
module rrb_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  rrb_pkg::cell_ctrl_t ctrl,
    input  logic [31:0]         key_a,
    input  logic [31:0]         key_b,
    input  logic [31:0]         wr_seq,
    input  logic [31:0]         wr_payload,
    input  rrb_pkg::entry_t     prev_i,
    input  logic                taken_i,
    output logic                taken_o,
    input  logic [31:0]         sel_i,
    output logic [31:0]         sel_o,
    output logic                hit_a_o,
    output logic                hit_b_o,
    output rrb_pkg::entry_t     entry_o
);

    logic        valid_reg, valid_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] payload_reg, payload_next;
    logic        grant;

    assign grant   = ctrl.store & ~taken_i & ~valid_reg;
    assign taken_o = taken_i | ~valid_reg;
    assign hit_a_o = valid_reg && (seq_reg == key_a);
    assign hit_b_o = valid_reg && (seq_reg == key_b);
    assign sel_o   = sel_i | (hit_a_o ? payload_reg : 32'd0);

    assign entry_o.valid   = valid_reg;
    assign entry_o.seq     = seq_reg;
    assign entry_o.payload = payload_reg;

    always_comb begin
        valid_next   = valid_reg;
        seq_next     = seq_reg;
        payload_next = payload_reg;
        if (ctrl.rotate) begin
            valid_next   = prev_i.valid;
            seq_next     = prev_i.seq;
            payload_next = prev_i.payload;
        end else if (grant) begin
            valid_next   = 1'b1;
            seq_next     = wr_seq;
            payload_next = wr_payload;
        end else if (ctrl.clear_hit && hit_a_o) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        seq_reg     <= seq_next;
        payload_reg <= payload_next;
    end

endmodule

/* rtl/rrb_chain.sv */
// Ring of defer queue cells with free-slot and match-select chains.
`timescale 1ns / 1ps
module rrb_chain (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rrb_pkg::cell_ctrl_t  ctrl,
    input  logic [31:0]          key_a,
    input  logic [31:0]          key_b,
    input  logic [31:0]          wr_seq,
    input  logic [31:0]          wr_payload,
    output rrb_pkg::chain_stat_t stat
);

    localparam int N = rrb_pkg::QUEUE_DEPTH;

    rrb_pkg::entry_t entry_w [N];
    logic            taken_c [N+1];
    logic [31:0]     sel_c   [N+1];
    logic [N-1:0]    hit_a_w;
    logic [N-1:0]    hit_b_w;

    assign taken_c[0] = 1'b0;
    assign sel_c[0]   = 32'd0;

    for (genvar i = 0; i < N; i++) begin : g_cell
        rrb_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .key_a      (key_a),
            .key_b      (key_b),
            .wr_seq     (wr_seq),
            .wr_payload (wr_payload),
            .prev_i     (entry_w[(i + N - 1) % N]),
            .taken_i    (taken_c[i]),
            .taken_o    (taken_c[i+1]),
            .sel_i      (sel_c[i]),
            .sel_o      (sel_c[i+1]),
            .hit_a_o    (hit_a_w[i]),
            .hit_b_o    (hit_b_w[i]),
            .entry_o    (entry_w[i])
        );
    end

    assign stat.hit_a       = |hit_a_w;
    assign stat.hit_b       = |hit_b_w;
    assign stat.hit_payload = sel_c[N];
    assign stat.tail_valid  = entry_w[N-1].valid;
    assign stat.tail_seq    = entry_w[N-1].seq;

endmodule

/* rtl/redundancy_reorder_buffer_core.sv */
// Top level of the redundancy reorder buffer: control sequencer, config port, result register.
`timescale 1ns / 1ps
// Receive-side reorder buffer for a redundant channel. A receive transaction
// passes through ST_RECV; its verdict is registered there once the output
// register is free. A deliver emits up to 16 packets: the sequencer looks up
// one sequence number per cycle across the cell row while the output register
// is free. A timeout rotates the cell ring once to find the smallest queued
// number, then delivers from it, or reports K_NONE if the ring is empty. One
// transaction is worked on at a time; the next is accepted once the last
// result is in the output register. queue_limit sits at address 0 and resets to 16.
module redundancy_reorder_buffer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  rrb_pkg::item_t                 s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output rrb_pkg::res_t                  m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rrb_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RECV  = 3'd1;
    localparam logic [2:0] ST_TSCAN = 3'd2;
    localparam logic [2:0] ST_TEND  = 3'd3;
    localparam logic [2:0] ST_DELIV = 3'd4;

    localparam int CNT_W  = rrb_pkg::CNT_W;
    localparam int SCAN_W = rrb_pkg::SCAN_W;
    localparam int OUT_W  = rrb_pkg::OUT_W;

    logic [2:0]        state_reg, state_next;
    rrb_pkg::item_t    in_reg;
    logic [31:0]       expected_reg, expected_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [4:0]        queue_limit_reg;
    logic              min_valid_reg, min_valid_next;
    logic [31:0]       min_seq_reg, min_seq_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic [OUT_W-1:0]  n_reg, n_next;
    logic              m_valid_reg, m_valid_next;
    rrb_pkg::res_t     m_data_reg, m_data_next;

    rrb_pkg::cell_ctrl_t  cell_ctrl;
    rrb_pkg::chain_stat_t chain_stat;
    logic [31:0]          key_a;
    logic [31:0]          key_b;

    logic              out_free;
    logic              s_accept;
    logic [CNT_W-1:0]  limit_use;
    logic              full;
    logic [32:0]       window_end;
    logic [3:0]        verdict;
    logic              do_store;
    logic              deliv_last;
    logic              emit_deliv;
    logic              store_fire;
    logic              cfg_write;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid & s_ready;
    assign out_free = ~m_valid_reg | m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign prdata    = (paddr[2] == rrb_pkg::REG_QUEUE_LIMIT) ?
                       {27'd0, queue_limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            queue_limit_reg <= rrb_pkg::LIMIT_RESET;
        end else if (cfg_write && paddr[2] == rrb_pkg::REG_QUEUE_LIMIT) begin
            queue_limit_reg <= pwdata[4:0];
        end
    end

    always_comb begin
        if (queue_limit_reg == 5'd0) begin
            limit_use = CNT_W'(1);
        end else if ({27'd0, queue_limit_reg} > 32'(rrb_pkg::QUEUE_DEPTH)) begin
            limit_use = CNT_W'(rrb_pkg::QUEUE_DEPTH);
        end else begin
            limit_use = CNT_W'(queue_limit_reg);
        end
    end

    assign full       = (count_reg >= limit_use);
    assign window_end = {1'b0, expected_reg} +
                        33'(limit_use) * 33'(rrb_pkg::WINDOW_FACTOR);

    // receive verdict, key_a carries the received number in ST_RECV
    always_comb begin
        do_store = 1'b0;
        if (!in_reg.checksum_ok) begin
            verdict = rrb_pkg::V_BAD_CHECKSUM;
        end else if (expected_reg == 32'd0 && in_reg.tx_not_started &&
                     in_reg.seq_nr != 32'd0) begin
            verdict = rrb_pkg::V_FIRST_NOT_0;
        end else if (in_reg.seq_nr < expected_reg) begin
            verdict = rrb_pkg::V_OLD;
        end else if (in_reg.seq_nr == expected_reg) begin
            if (chain_stat.hit_a) begin
                verdict = rrb_pkg::V_IN_ORDER;
            end else if (full) begin
                verdict = rrb_pkg::V_IN_ORDER_FULL;
            end else begin
                verdict  = rrb_pkg::V_IN_ORDER;
                do_store = 1'b1;
            end
        end else if ({1'b0, in_reg.seq_nr} > window_end) begin
            verdict = rrb_pkg::V_BEYOND_WIN;
        end else if (chain_stat.hit_a) begin
            verdict = rrb_pkg::V_DUPLICATE;
        end else if (full) begin
            verdict = rrb_pkg::V_FULL;
        end else begin
            verdict  = rrb_pkg::V_STORED_AHEAD;
            do_store = 1'b1;
        end
    end

    assign deliv_last = (n_reg == OUT_W'(rrb_pkg::MAX_OUT - 1)) | ~chain_stat.hit_b;

    always_comb begin
        state_next     = state_reg;
        expected_next  = expected_reg;
        count_next     = count_reg;
        min_valid_next = min_valid_reg;
        min_seq_next   = min_seq_reg;
        scan_next      = scan_reg;
        n_next         = n_reg;
        m_valid_next   = m_valid_reg & ~m_ready;
        m_data_next    = m_data_reg;
        cell_ctrl      = '0;
        key_a          = in_reg.seq_nr;
        key_b          = expected_reg + 32'd1;
        emit_deliv     = 1'b0;
        store_fire     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (s_data.action)
                        rrb_pkg::A_RECEIVE: begin
                            state_next = ST_RECV;
                        end
                        rrb_pkg::A_DELIVER: begin
                            n_next     = '0;
                            state_next = ST_DELIV;
                        end
                        rrb_pkg::A_TIMEOUT: begin
                            min_valid_next = 1'b0;
                            scan_next      = '0;
                            state_next     = ST_TSCAN;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RECV: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.kind        = rrb_pkg::K_VERDICT;
                    m_data_next.verdict     = verdict;
                    m_data_next.out_seq     = 32'd0;
                    m_data_next.out_payload = 32'd0;
                    m_data_next.last        = 1'b1;
                    if (do_store) begin
                        cell_ctrl.store = 1'b1;
                        store_fire      = 1'b1;
                        count_next      = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_TSCAN: begin
                cell_ctrl.rotate = 1'b1;
                if (chain_stat.tail_valid &&
                    (!min_valid_reg || chain_stat.tail_seq < min_seq_reg)) begin
                    min_valid_next = 1'b1;
                    min_seq_next   = chain_stat.tail_seq;
                end
                scan_next = scan_reg + SCAN_W'(1);
                if (scan_reg == SCAN_W'(rrb_pkg::QUEUE_DEPTH - 1)) begin
                    state_next = ST_TEND;
                end
            end
            ST_TEND: begin
                if (min_valid_reg) begin
                    expected_next = min_seq_reg;
                    n_next        = '0;
                    state_next    = ST_DELIV;
                end else if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.kind        = rrb_pkg::K_NONE;
                    m_data_next.verdict     = 4'd0;
                    m_data_next.out_seq     = 32'd0;
                    m_data_next.out_payload = 32'd0;
                    m_data_next.last        = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            ST_DELIV: begin
                key_a = expected_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (chain_stat.hit_a) begin
                        emit_deliv              = 1'b1;
                        cell_ctrl.clear_hit     = 1'b1;
                        m_data_next.kind        = rrb_pkg::K_DELIVERED;
                        m_data_next.verdict     = 4'd0;
                        m_data_next.out_seq     = expected_reg;
                        m_data_next.out_payload = chain_stat.hit_payload;
                        m_data_next.last        = deliv_last;
                        expected_next           = expected_reg + 32'd1;
                        count_next              = count_reg - CNT_W'(1);
                        n_next                  = n_reg + OUT_W'(1);
                        if (deliv_last) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_data_next.kind        = rrb_pkg::K_NONE;
                        m_data_next.verdict     = 4'd0;
                        m_data_next.out_seq     = 32'd0;
                        m_data_next.out_payload = 32'd0;
                        m_data_next.last        = 1'b1;
                        state_next              = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            expected_reg  <= 32'd0;
            count_reg     <= '0;
            min_valid_reg <= 1'b0;
            scan_reg      <= '0;
            n_reg         <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            expected_reg  <= expected_next;
            count_reg     <= count_next;
            min_valid_reg <= min_valid_next;
            scan_reg      <= scan_next;
            n_reg         <= n_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        min_seq_reg <= min_seq_next;
        m_data_reg  <= m_data_next;
        if (s_accept) begin
            in_reg <= s_data;
        end
    end

    rrb_chain u_chain (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (cell_ctrl),
        .key_a      (key_a),
        .key_b      (key_b),
        .wr_seq     (in_reg.seq_nr),
        .wr_payload (in_reg.payload_tag),
        .stat       (chain_stat)
    );

    a_deliv_step: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_deliv |=> expected_reg == $past(expected_reg) + 32'd1)
        else $error("expected number did not advance after a delivery");

    a_store_count: assert property (@(posedge aclk) disable iff (!aresetn)
        store_fire |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("entry count did not follow a store");

    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TSCAN && scan_reg == SCAN_W'(rrb_pkg::QUEUE_DEPTH - 1))
        |=> state_reg == ST_TEND)
        else $error("ring scan did not end after one full rotation");

    a_run_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DELIV && n_reg != '0) |-> chain_stat.hit_a)
        else $error("delivery run continued without a queued successor");

endmodule
